// File: rtl/serial_line_assembler_top_defines.svh
// assertion macros for the serial line assembler
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef SERIAL_LINE_ASSEMBLER_TOP_DEFINES_SVH
`define SERIAL_LINE_ASSEMBLER_TOP_DEFINES_SVH

// property checked on every rising edge outside reset
`define SLA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define SLA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    `SLA_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// File: rtl/sla_pkg.sv
// shared types, codes and constants for the serial line assembler
// no dependencies
package sla_pkg;

    localparam int LINE_SIZE_DEF = 64;
    localparam int LINE_SIZE_MAX = 64;
    localparam int CMD_LEN_W     = $clog2(LINE_SIZE_MAX + 1);
    localparam int CMD_DEPTH     = 2;
    localparam int KIND_W        = 2;
    localparam int CHAR_W        = 8;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 8;

    localparam logic [7:0] CH_LOW  = 8'h20;
    localparam logic [7:0] CH_HIGH = 8'h7E;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_BS   = 8'h08;

    typedef enum logic [KIND_W-1:0] {
        KIND_CHAR     = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_OVERFLOW = 2'd2
    } t_kind;

    typedef enum logic {
        OP_LINE     = 1'b0,
        OP_OVERFLOW = 1'b1
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [CMD_LEN_W-1:0] len;
    } t_cmd;

endpackage

// File: rtl/sla_front.sv
// front end: accepts bytes, edits the line store and queues line and overflow commands
// depends on sla_pkg
module sla_front #(
    parameter int  LINE_SIZE = sla_pkg::LINE_SIZE_DEF,
    localparam int ADDR_W    = $clog2(LINE_SIZE)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [sla_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                            o_push,
    output sla_pkg::t_cmd                   o_cmd,
    input  logic                            i_fifo_full,
    input  logic                            i_line_done,
    input  logic [ADDR_W-1:0]               i_rd_addr,
    output logic [sla_pkg::CHAR_W-1:0]      o_rd_data
);
    import sla_pkg::*;

    localparam int FILL_W = $clog2(LINE_SIZE + 1);

    logic [CHAR_W-1:0] r_mem [LINE_SIZE];
    logic [CHAR_W-1:0] r_rd_a;
    logic [CHAR_W-1:0] r_rd_b;

    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_last_cr, n_last_cr;
    logic              r_reload, n_reload;
    logic              r_line_wait, n_line_wait;

    logic              accept;
    logic              is_term;
    logic              is_full;
    logic              is_store;
    logic              wr_en;
    logic [7:0]        c;
    logic [FILL_W-1:0] fill_m2;
    logic [ADDR_W-1:0] rd_a_addr;

    assign c          = i_s_tdata;
    assign o_s_tready = !r_reload && !r_line_wait && !i_fifo_full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign is_term    = (c == CH_LF) && (r_fill != '0) && r_last_cr;
    assign is_full    = r_fill >= FILL_W'(LINE_SIZE);
    assign is_store   = ((c >= CH_LOW) && (c <= CH_HIGH)) || (c == CH_CR);
    assign fill_m2    = r_fill - FILL_W'(2);
    assign rd_a_addr  = fill_m2[ADDR_W-1:0];
    assign o_rd_data  = r_rd_b;

    always_comb begin
        n_fill      = r_fill;
        n_last_cr   = r_last_cr;
        n_reload    = 1'b0;
        n_line_wait = r_line_wait;
        o_push      = 1'b0;
        o_cmd       = '{op: OP_LINE, len: '0};
        wr_en       = 1'b0;

        // byte before the new end of line comes back from the store
        if (r_reload) begin
            n_last_cr = (r_rd_a == CH_CR);
        end
        if (i_line_done) begin
            n_line_wait = 1'b0;
        end

        if (accept) begin
            if (is_term) begin
                o_push      = 1'b1;
                o_cmd.op    = OP_LINE;
                o_cmd.len   = CMD_LEN_W'(r_fill - 1'b1);
                n_fill      = '0;
                n_line_wait = 1'b1;
            end else if (c == CH_BS) begin
                if (r_fill != '0) begin
                    n_fill = r_fill - 1'b1;
                    if (r_fill > FILL_W'(1)) begin
                        n_reload = 1'b1;
                    end
                end
            end else if (is_full) begin
                o_push   = 1'b1;
                o_cmd.op = OP_OVERFLOW;
                n_fill   = '0;
            end else if (is_store) begin
                wr_en     = 1'b1;
                n_fill    = r_fill + 1'b1;
                n_last_cr = (c == CH_CR);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_last_cr   <= 1'b0;
            r_reload    <= 1'b0;
            r_line_wait <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_last_cr   <= n_last_cr;
            r_reload    <= n_reload;
            r_line_wait <= n_line_wait;
        end
    end

    // line store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_fill[ADDR_W-1:0]] <= c;
        end
        r_rd_a <= r_mem[rd_a_addr];
        r_rd_b <= r_mem[i_rd_addr];
    end

endmodule

// File: rtl/sla_cmd_fifo.sv
// short command queue between front end and back end
// depends on sla_pkg
module sla_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sla_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output sla_pkg::t_cmd o_cmd,
    output logic          o_empty,
    output logic          o_full
);
    import sla_pkg::*;

    localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    t_cmd             r_slot [CMD_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(CMD_DEPTH));
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(CMD_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: rtl/sla_back.sv
// back end: carries out queued commands and drives the registered result stream
// depends on sla_pkg; reads the line store held in sla_front
module sla_back #(
    parameter int  LINE_SIZE = sla_pkg::LINE_SIZE_DEF,
    localparam int ADDR_W    = $clog2(LINE_SIZE)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sla_pkg::t_cmd                   i_cmd,
    input  logic                            i_empty,
    output logic                            o_pop,
    output logic [ADDR_W-1:0]               o_rd_addr,
    input  logic [sla_pkg::CHAR_W-1:0]      i_rd_data,
    output logic                            o_line_done,
    output logic                            o_draining,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [sla_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic [sla_pkg::KIND_W-1:0]      o_m_tuser,
    output logic                            o_m_tlast
);
    import sla_pkg::*;

    localparam int FILL_W = $clog2(LINE_SIZE + 1);

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_state;

    t_state            r_state;
    logic [FILL_W-1:0] r_idx;
    logic [FILL_W-1:0] r_len;
    logic              r_m_valid;
    t_kind             r_kind;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;

    logic              slot_free;
    logic              line_end;
    logic              empty_line;
    logic              out_load;
    logic [FILL_W-1:0] idx_inc;
    logic [FILL_W-1:0] rd_idx;

    assign slot_free  = !r_m_valid || i_m_tready;
    assign idx_inc    = r_idx + 1'b1;
    assign line_end   = (idx_inc == r_len);
    assign o_pop      = (r_state == ST_IDLE) && !i_empty && slot_free;
    assign empty_line = (i_cmd.op == OP_LINE) && (i_cmd.len == '0);
    assign o_draining = (r_state == ST_DRAIN);

    // output register takes a new item this cycle
    assign out_load = (o_pop && ((i_cmd.op == OP_OVERFLOW) || empty_line))
                   || ((r_state == ST_DRAIN) && slot_free);

    // prefetch: address runs one ahead whenever a character leaves
    assign rd_idx    = (r_state == ST_DRAIN && slot_free) ? idx_inc : r_idx;
    assign o_rd_addr = (r_state == ST_IDLE) ? '0 : rd_idx[ADDR_W-1:0];

    assign o_line_done = (o_pop && empty_line)
                      || ((r_state == ST_DRAIN) && slot_free && line_end);

    assign o_m_tvalid = r_m_valid;
    assign o_m_tlast  = r_last;
    assign o_m_tdata  = r_char;
    assign o_m_tuser  = r_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        if (i_cmd.op == OP_OVERFLOW) begin
                            r_kind    <= KIND_OVERFLOW;
                            r_char    <= '0;
                            r_last    <= 1'b1;
                        end else if (empty_line) begin
                            r_kind    <= KIND_EMPTY;
                            r_char    <= '0;
                            r_last    <= 1'b1;
                        end else begin
                            r_state <= ST_DRAIN;
                            r_idx   <= '0;
                            r_len   <= i_cmd.len[FILL_W-1:0];
                        end
                    end
                end
                ST_DRAIN: begin
                    if (slot_free) begin
                        r_kind    <= KIND_CHAR;
                        r_char    <= i_rd_data;
                        r_last    <= line_end;
                        r_idx     <= idx_inc;
                        if (line_end) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/serial_line_assembler_top.sv
// top level of the serial line assembler: front end, command queue, back end
// depends on sla_pkg, sla_front, sla_cmd_fifo, sla_back and the assertion macro header
//
// usage
//   slave channel: one received console byte per item in i_s_tdata[7:0]
//   master channel: result items, tuser[1:0] kind (0 char, 1 empty line, 2 overflow),
//   tdata[7:0] line character (zero unless kind is char), tlast on the last item of a run
//   printable bytes and carriage return go into the line store, backspace drops the
//   last stored byte, a line feed after a stored carriage return ends the line and
//   the line comes out without that carriage return; any byte into a full store but
//   a backspace or a line-ending line feed gives one overflow item and empties the line
// timing
//   storing bytes are taken one per cycle while tready is high; a backspace that
//   leaves one or more bytes holds tready low while the store reads back the byte
//   before the new end; a status item passes the command queue and the output register,
//   a line's characters also the drain state, then go one per cycle while taken
//   from a line feed that ends a line until its last character is in the output
//   register the slave channel is held off, as the store's read port drains the line
// reset and stall
//   reset empties the line, the command queue and the output register
//   a stalled receiver holds the output register; bytes are still taken until a line
//   end waits for its drain or the two-entry command queue fills, then tready drops
`include "serial_line_assembler_top_defines.svh"

module serial_line_assembler_top #(
    parameter int LINE_SIZE = sla_pkg::LINE_SIZE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side, tdata: [7:0] rx_byte
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [sla_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // master side, tdata: [7:0] line_char
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [sla_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // master side, tuser: [1:0] kind
    output logic [sla_pkg::KIND_W-1:0]      o_m_tuser,
    output logic                            o_m_tlast
);
    import sla_pkg::*;

    localparam int ADDR_W = $clog2(LINE_SIZE);

    // command path front to back
    logic              w_push;
    t_cmd              w_push_cmd;
    logic              w_pop;
    t_cmd              w_pop_cmd;
    logic              w_empty;
    logic              w_full;

    // line store read port used by the back end
    logic [ADDR_W-1:0] w_rd_addr;
    logic [CHAR_W-1:0] w_rd_data;

    // back end status
    logic              w_line_done;
    logic              w_draining;

    sla_front #(
        .LINE_SIZE (LINE_SIZE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd),
        .i_fifo_full (w_full),
        .i_line_done (w_line_done),
        .i_rd_addr   (w_rd_addr),
        .o_rd_data   (w_rd_data)
    );

    sla_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_pop_cmd),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    sla_back #(
        .LINE_SIZE (LINE_SIZE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_pop_cmd),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_line_done (w_line_done),
        .o_draining  (w_draining),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    // the store must not change while a line is read out of it
    `SLA_ASSERT_IMPLY(a_no_accept_while_draining, w_draining, !o_s_tready, "byte taken in drain")

    // the front end never pushes into a full queue
    `SLA_ASSERT_IMPLY(a_no_push_when_full, w_push, !w_full, "command pushed into full queue")

    // empty-line and overflow items are single-item runs with a zero character
    `SLA_ASSERT_IMPLY(a_status_item_form, o_m_tvalid && (o_m_tuser != KIND_CHAR), o_m_tlast && (o_m_tdata == '0), "bad status item")

endmodule

// File: verif/testbench.sv
// self-checking bench for serial_line_assembler_top: byte stream in, line items out
// depends on sla_pkg and the rtl of the block; predicts every item in a scoreboard class
module testbench;
    import sla_pkg::*;

    localparam int LINE_SIZE    = LINE_SIZE_DEF;
    localparam int HOLD_CYCLES  = 200;   // long receiver hold-off to back the block up
    localparam int STALL_LIMIT  = 2000;  // cycles with no item moving on either side
    localparam int DRAIN_CYCLES = 20;    // settle time after the last expected item
    localparam int PHASE_ITEMS  = 75;    // bytes each phase sends at least, its full line included

    // how a line that fills the whole store is closed
    typedef enum int {
        FULL_TERMINATE,  // cr as the last stored byte, then lf
        FULL_BACKSPACE,  // backspace on a full store, then cr lf
        FULL_OTHER,      // any other byte, an overflow
        FULL_BARE_LF     // lf after a printable byte on a full store, an overflow
    } t_full_end;

    typedef struct {
        t_kind             kind;
        logic [CHAR_W-1:0] line_char;
        logic              last;
    } t_line_item;

    // line editor behaviour and the items it still owes
    class line_scoreboard;
        logic [CHAR_W-1:0] line_store [LINE_SIZE];
        int unsigned       fill_count = 0;
        t_line_item        owed_items [$];
        int unsigned       mismatches = 0;

        function void owe(t_kind kind, logic [CHAR_W-1:0] line_char, logic last);
            t_line_item item;
            item.kind      = kind;
            item.line_char = line_char;
            item.last      = last;
            owed_items.push_back(item);
        endfunction

        // one accepted console byte
        function void note_byte(logic [7:0] rx);
            int unsigned i;
            if (rx == CH_LF && fill_count > 0 && line_store[fill_count - 1] == CH_CR) begin
                // terminator wins even on a full store
                if (fill_count == 1) begin
                    owe(KIND_EMPTY, '0, 1'b1);
                end else begin
                    for (i = 0; i < fill_count - 1; i++)
                        owe(KIND_CHAR, line_store[i], i == fill_count - 2);
                end
                fill_count = 0;
            end else if (rx == CH_BS) begin
                if (fill_count > 0)
                    fill_count--;
            end else if (fill_count >= LINE_SIZE) begin
                fill_count = 0;
                owe(KIND_OVERFLOW, '0, 1'b1);
            end else if ((rx >= CH_LOW && rx <= CH_HIGH) || rx == CH_CR) begin
                line_store[fill_count] = rx;
                fill_count++;
            end
        endfunction

        // one accepted result item against the oldest owed one
        function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic [KIND_W-1:0] tuser,
                                   logic tlast);
            t_line_item want;
            if (owed_items.size() == 0) begin
                $error("unexpected item: tdata %h tuser %h tlast %b", tdata, tuser, tlast);
                mismatches++;
                return;
            end
            want = owed_items.pop_front();
            if (tuser !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, tuser);
                mismatches++;
            end
            if (tdata !== want.line_char) begin
                $error("line_char: expected %h, got %h", want.line_char, tdata);
                mismatches++;
            end
            if (tlast !== want.last) begin
                $error("last: expected %b, got %b", want.last, tlast);
                mismatches++;
            end
        endfunction
    endclass

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;    // [7:0] rx_byte
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;          // [7:0] line_char
    logic [KIND_W-1:0]      o_m_tuser;          // [1:0] kind
    logic                   o_m_tlast;

    line_scoreboard sb;

    int src_idle_pct   = 0;   // chance in a hundred that the sender idles a cycle
    int sink_stall_pct = 0;   // chance in a hundred that the receiver stalls a cycle
    int hold_req       = 0;   // bumped by the stimulus to ask for a long hold-off
    int hold_served    = 0;
    int hold_left      = 0;
    int sent_items     = 0;
    int quiet_cycles   = 0;

    // short directed run: empty-store lf and backspace, empty line, field extremes,
    // dropped control bytes, editing, lf after a non-cr byte, cr inside a line
    logic [7:0] directed_bytes [$] = '{
        CH_LF, CH_BS, CH_CR, CH_LF,
        CH_LOW, CH_HIGH, 8'h1F, 8'h7F, 8'h00, 8'hFF, CH_CR, CH_LF,
        8'h41, 8'h42, CH_BS, 8'h43, CH_LF, CH_CR, CH_BS, CH_CR, CH_LF,
        CH_CR, 8'h78, CH_CR, CH_LF
    };

    serial_line_assembler_top #(
        .LINE_SIZE (LINE_SIZE)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // receiver: checks every accepted item, stalls at random, and serves
    // the long hold-off when the stimulus asks for one
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata, o_m_tuser, o_m_tlast);
        if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (hold_req != hold_served) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            i_m_tready  <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // watchdog: any item moving on either side restarts the count
    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("** serial_line_assembler_top: FAILED **");
        $finish;
    end

    function automatic logic [7:0] printable();
        return 8'($urandom_range(CH_HIGH, CH_LOW));
    endfunction

    // offer one byte until taken, then maybe idle for a while
    task automatic send_byte(logic [7:0] rx);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= rx;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_byte(rx);
        sent_items++;
        if ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
    endtask

    // well-formed line with the odd backspace and the odd cr in its body
    task automatic send_line(int unsigned len);
        int unsigned i;
        for (i = 0; i < len; i++) begin
            if (i > 0 && $urandom_range(7) == 0)
                send_byte(CH_BS);
            send_byte(($urandom_range(15) == 0) ? CH_CR : printable());
        end
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(4, 1))
            send_byte(8'($urandom));
    endtask

    // sequences that look like lines but do not end as one
    task automatic send_broken();
        case ($urandom_range(2))
            0: begin
                repeat ($urandom_range(3, 1))
                    send_byte(printable());
                send_byte(CH_LF);
                send_byte(CH_BS);
            end
            1: begin
                send_byte(CH_CR);
                send_byte(CH_BS);
                send_byte(CH_LF);
            end
            default: begin
                send_byte(CH_CR);
                send_byte(printable());
                send_byte(CH_LF);
            end
        endcase
    endtask

    // fill the store to the brim, then close it the way asked
    task automatic send_full_line(t_full_end how);
        logic [7:0] other;
        while (sb.fill_count < LINE_SIZE - 1)
            send_byte(printable());
        case (how)
            FULL_TERMINATE: begin
                send_byte(CH_CR);
                send_byte(CH_LF);
            end
            FULL_BACKSPACE: begin
                send_byte(printable());
                send_byte(CH_BS);
                send_byte(CH_CR);
                send_byte(CH_LF);
            end
            FULL_OTHER: begin
                send_byte(printable());
                do other = 8'($urandom); while (other == CH_BS);
                send_byte(other);
            end
            default: begin
                send_byte(printable());
                send_byte(CH_LF);
            end
        endcase
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, t_full_end how);
        int phase_start;
        int pick;
        src_idle_pct   = idle_pct;
        sink_stall_pct <= stall_pct;
        phase_start    = sent_items;
        send_full_line(how);
        while (sent_items - phase_start < PHASE_ITEMS) begin
            pick = $urandom_range(9);
            if (pick < 6)
                send_line($urandom_range(12, 0));
            else if (pick < 8)
                send_broken();
            else
                send_noise();
        end
    endtask

    initial begin
        sb = new;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        // receiver holds off while short lines keep coming, so a line end waits
        // for its drain and the slave side has to stall
        hold_req <= hold_req + 1;
        repeat (5) send_line(2);

        run_phase(0, 0, FULL_TERMINATE);
        run_phase(73, 0, FULL_BACKSPACE);
        run_phase(0, 73, FULL_OTHER);
        run_phase(31, 31, FULL_BARE_LF);
        i_s_tvalid <= 1'b0;

        // the watchdog covers items that never turn up
        while (sb.owed_items.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("** serial_line_assembler_top: PASSED **");
        else
            $display("** serial_line_assembler_top: FAILED **");
        $finish;
    end

endmodule
